[hdl/assert_macros.svh]
// Assertion macros for the job assigner, included by the scan sequencer llja_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset
`define LLJA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication
`define LLJA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LLJA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/llja_pkg.sv]
// Types and constants of the least-loaded job assigner
`timescale 1ns / 1ps

package llja_pkg;

  localparam int LOAD_W    = 24;
  localparam int COST_W    = 12;
  localparam int WEIGHT_W  = 8;
  localparam int FACTOR_W  = 4;
  localparam int JOBNUM_W  = 16;
  localparam int MIDX_W    = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_MODE_ZERO = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_MODE_ONE  = CFG_IDX_W'(1);

  localparam logic [FACTOR_W-1:0] FACTOR_MODE_ZERO_RST = FACTOR_W'(2);
  localparam logic [FACTOR_W-1:0] FACTOR_MODE_ONE_RST  = FACTOR_W'(4);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } llja_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } llja_mem_cmd_t;

endpackage

[hdl/llja_load_mem.sv]
// Load table memory: one read and one write port, registered read, per-entry valid bits
`timescale 1ns / 1ps

module llja_load_mem #(
  parameter int NUM_MACHINES = 8,
  parameter int IDX_W        = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  llja_pkg::llja_mem_cmd_t     cmd,
  input  logic [IDX_W-1:0]            rd_addr,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [llja_pkg::LOAD_W-1:0] wr_data,
  output logic [llja_pkg::LOAD_W-1:0] rd_data
);
  import llja_pkg::*;

  logic [LOAD_W-1:0]       load_mem_r [NUM_MACHINES];
  logic [NUM_MACHINES-1:0] vld_r;
  logic [LOAD_W-1:0]       rd_data_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      load_mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= load_mem_r[rd_addr];
    end
  end

  // entries never written since reset read as zero load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[hdl/llja_ctrl.sv]
// Scan sequencer: reads every load, keeps the minimum, writes back the updated load
`timescale 1ns / 1ps
`include "assert_macros.svh"

module llja_ctrl #(
  parameter int NUM_MACHINES = 8,
  parameter int IDX_W        = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [llja_pkg::FACTOR_W-1:0] factor_mode_zero,
  input  logic [llja_pkg::FACTOR_W-1:0] factor_mode_one,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_job_mode,
  input  logic [llja_pkg::WEIGHT_W-1:0] in_job_weight,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [llja_pkg::JOBNUM_W-1:0] out_job_number,
  output logic [llja_pkg::MIDX_W-1:0]   out_machine_index,
  output logic [llja_pkg::LOAD_W-1:0]   out_machine_load,
  output llja_pkg::llja_mem_cmd_t       mem_cmd,
  output logic [IDX_W-1:0]              rd_addr,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [llja_pkg::LOAD_W-1:0]   wr_data,
  input  logic [llja_pkg::LOAD_W-1:0]   rd_data
);
  import llja_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MACHINES - 1);

  llja_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                rsp_vld_r;
  logic [IDX_W-1:0]    rsp_idx_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [LOAD_W-1:0]   best_load_r;
  logic [COST_W-1:0]   cost_r, cost_nxt;
  logic [JOBNUM_W-1:0] job_cnt_r, job_cnt_nxt;
  logic                out_valid_r;
  logic [JOBNUM_W-1:0] out_job_number_r;
  logic [MIDX_W-1:0]   out_machine_index_r;
  logic [LOAD_W-1:0]   out_machine_load_r;

  logic                in_accept;
  logic                upd_go;
  logic [FACTOR_W-1:0] factor_sel;
  logic [LOAD_W:0]     sum_wide;
  logic [LOAD_W-1:0]   sum_sat;
  logic [IDX_W+MIDX_W-1:0] idx_ext;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_cnt_r == LAST_IDX) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_stall      = 1'b1;
    mem_cmd.rd_en = 1'b0;
    upd_go        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        mem_cmd.rd_en = in_valid;
      end
      ST_SCAN: begin
        mem_cmd.rd_en = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_UPDATE: begin
        // hold while the previous result is still stalled
        upd_go = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
    mem_cmd.wr_en = upd_go;
  end

  assign in_accept = in_valid && !in_stall;

  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    if (mem_cmd.rd_en) begin
      rd_cnt_nxt = (rd_cnt_r == LAST_IDX) ? '0 : rd_cnt_r + 1'b1;
    end
  end

  assign factor_sel = in_job_mode ? factor_mode_one : factor_mode_zero;
  assign cost_nxt   = COST_W'(in_job_weight) * COST_W'(factor_sel);

  assign sum_wide = {1'b0, best_load_r} + (LOAD_W + 1)'(cost_r);
  assign sum_sat  = sum_wide[LOAD_W] ? {LOAD_W{1'b1}} : sum_wide[LOAD_W-1:0];

  assign job_cnt_nxt = job_cnt_r + 1'b1;
  assign idx_ext     = (IDX_W + MIDX_W)'(best_idx_r);

  assign rd_addr = rd_cnt_r;
  assign wr_addr = best_idx_r;
  assign wr_data = sum_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      rsp_vld_r   <= 1'b0;
      job_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      rsp_vld_r <= mem_cmd.rd_en;
      if (upd_go) begin
        job_cnt_r   <= job_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath: running minimum, cost and result registers
  always_ff @(posedge clk) begin
    rsp_idx_r <= rd_cnt_r;
    if (in_accept) begin
      cost_r <= cost_nxt;
    end
    // first entry seeds the minimum; strict less keeps the lowest index on ties
    if (rsp_vld_r && (rsp_idx_r == '0 || rd_data < best_load_r)) begin
      best_idx_r  <= rsp_idx_r;
      best_load_r <= rd_data;
    end
    if (upd_go) begin
      out_job_number_r    <= job_cnt_nxt;
      out_machine_index_r <= idx_ext[MIDX_W-1:0];
      out_machine_load_r  <= sum_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_job_number    = out_job_number_r;
  assign out_machine_index = out_machine_index_r;
  assign out_machine_load  = out_machine_load_r;

  `LLJA_ASSERT_IMP(a_no_wr_during_rd, clk, rst_n, mem_cmd.wr_en, !rsp_vld_r && !mem_cmd.rd_en, "load write overlaps a scan read")
  `LLJA_ASSERT_IMP(a_scan_len, clk, rst_n, in_accept, ##(NUM_MACHINES + 1) (state_r == ST_UPDATE), "scan did not reach update on time")
  `LLJA_ASSERT_IMP(a_rose_after_wr, clk, rst_n, $rose(out_valid_r), $past(mem_cmd.wr_en), "result shown without load write")
  `LLJA_ASSERT_NXT(a_cnt_step, clk, rst_n, upd_go, job_cnt_r == $past(job_cnt_nxt), "job counter did not advance")
  `LLJA_ASSERT_IMP(a_best_range, clk, rst_n, state_r == ST_UPDATE, best_idx_r <= LAST_IDX, "chosen machine out of range")

endmodule

[hdl/least_loaded_job_assigner.sv]
// Top level of the least-loaded job assigner: configuration registers and submodules
//
// Usage:
//   Input channel (in_valid / in_stall): one job per transfer, a mode bit and
//   an 8-bit weight. Output channel (out_valid / out_stall): one result per
//   job, giving the job number, the chosen machine and its new load.
//   Configuration (cfg_valid / cfg_ready): cfg_index 0 writes the mode-zero
//   factor, 1 the mode-one factor; other indexes are dropped. cfg_ready is
//   always high. Write only while no job is in flight.
//   Sequence: one job at a time. The load memory's single read port scans
//   one entry per cycle, then the DRAIN state lets the last read return and
//   the UPDATE state writes the new load and the result register. The next
//   job is taken in the cycle after the write.
//   Reset: all loads read as zero, the job count clears, factors return to 2
//   and 4. No clearing pass is needed.
//   Stall: a stalled result holds in the output register; the next job is
//   still taken and scanned, and waits before its write until the held
//   result is transferred.
`timescale 1ns / 1ps

module least_loaded_job_assigner #(
  parameter int NUM_MACHINES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_job_mode,
  input  logic [llja_pkg::WEIGHT_W-1:0]  in_job_weight,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [llja_pkg::JOBNUM_W-1:0]  out_job_number,
  output logic [llja_pkg::MIDX_W-1:0]    out_machine_index,
  output logic [llja_pkg::LOAD_W-1:0]    out_machine_load,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [llja_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [llja_pkg::FACTOR_W-1:0]  cfg_wdata
);
  import llja_pkg::*;

  localparam int IDX_W = $clog2(NUM_MACHINES);

  logic [FACTOR_W-1:0] factor_mode_zero_r;
  logic [FACTOR_W-1:0] factor_mode_one_r;
  llja_mem_cmd_t       mem_cmd;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic [LOAD_W-1:0]   wr_data;
  logic [LOAD_W-1:0]   rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_mode_zero_r <= FACTOR_MODE_ZERO_RST;
      factor_mode_one_r  <= FACTOR_MODE_ONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FACTOR_MODE_ZERO: factor_mode_zero_r <= cfg_wdata;
        REG_FACTOR_MODE_ONE:  factor_mode_one_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  llja_ctrl #(
    .NUM_MACHINES (NUM_MACHINES),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .factor_mode_zero  (factor_mode_zero_r),
    .factor_mode_one   (factor_mode_one_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_job_mode       (in_job_mode),
    .in_job_weight     (in_job_weight),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_job_number    (out_job_number),
    .out_machine_index (out_machine_index),
    .out_machine_load  (out_machine_load),
    .mem_cmd           (mem_cmd),
    .rd_addr           (rd_addr),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_data           (rd_data)
  );

  llja_load_mem #(
    .NUM_MACHINES (NUM_MACHINES),
    .IDX_W        (IDX_W)
  ) u_load_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mem_cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

[tb/least_loaded_job_assigner_tb.sv]
// Self-checking testbench for the least-loaded job assigner
`timescale 1ns / 1ps

module least_loaded_job_assigner_tb;
  import llja_pkg::*;

  localparam int MACHINES = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_PHASES = 6;
  localparam int JOBS_PER_PHASE = 95;
  localparam int BURST_JOBS = 24;

  localparam logic MODE_ZERO = 1'b0;
  localparam logic MODE_ONE  = 1'b1;

  localparam logic [FACTOR_W-1:0] DEFAULT_FACTOR_ZERO = FACTOR_W'(2);
  localparam logic [FACTOR_W-1:0] DEFAULT_FACTOR_ONE  = FACTOR_W'(4);
  localparam logic [FACTOR_W-1:0] FACTOR_MAX          = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX          = '1;
  localparam logic [LOAD_W-1:0]   LOAD_MAX            = '1;

  typedef struct packed {
    logic [JOBNUM_W-1:0] job_number;
    logic [MIDX_W-1:0]   machine_index;
    logic [LOAD_W-1:0]   machine_load;
  } job_result_t;

  class assignment_ledger;
    logic [LOAD_W-1:0]   machine_loads [MACHINES];
    logic [JOBNUM_W-1:0] jobs_assigned;
    logic [FACTOR_W-1:0] factor_zero;
    logic [FACTOR_W-1:0] factor_one;
    job_result_t         pending_assignments [$];
    int                  mismatch_count;

    function new();
      foreach (machine_loads[k]) machine_loads[k] = '0;
      jobs_assigned = '0;
      factor_zero = DEFAULT_FACTOR_ZERO;
      factor_one = DEFAULT_FACTOR_ONE;
      mismatch_count = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [FACTOR_W-1:0] value);
      if (index == REG_FACTOR_MODE_ZERO) begin
        factor_zero = value;
      end else if (index == REG_FACTOR_MODE_ONE) begin
        factor_one = value;
      end
    endfunction

    function void predict_assignment(logic mode, logic [WEIGHT_W-1:0] weight);
      logic [COST_W-1:0] cost;
      logic [LOAD_W:0]   sum;
      int                best;
      job_result_t       res;
      cost = weight * ((mode == MODE_ONE) ? factor_one : factor_zero);
      best = 0;
      // strict compare keeps ties on the lowest index
      for (int k = 1; k < MACHINES; k++) begin
        if (machine_loads[k] < machine_loads[best]) best = k;
      end
      sum = machine_loads[best] + cost;
      if (sum > LOAD_MAX) sum = LOAD_MAX;
      machine_loads[best] = sum[LOAD_W-1:0];
      jobs_assigned = jobs_assigned + 1'b1;
      res.job_number = jobs_assigned;
      res.machine_index = best[MIDX_W-1:0];
      res.machine_load = sum[LOAD_W-1:0];
      pending_assignments = {pending_assignments, res};
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_assignment(logic [JOBNUM_W-1:0] number, logic [MIDX_W-1:0] machine,
                          logic [LOAD_W-1:0] load);
      job_result_t want;
      if (pending_assignments.size() == 0) begin
        report_mismatch($sformatf("unexpected result: job %0d machine %0d load %0d",
                                  number, machine, load));
        return;
      end
      want = pending_assignments.pop_front();
      if (number !== want.job_number)
        report_mismatch($sformatf("job_number got %0d want %0d", number, want.job_number));
      if (machine !== want.machine_index)
        report_mismatch($sformatf("job %0d machine_index got %0d want %0d",
                                  want.job_number, machine, want.machine_index));
      if (load !== want.machine_load)
        report_mismatch($sformatf("job %0d machine_load got %0d want %0d",
                                  want.job_number, load, want.machine_load));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_job_mode = MODE_ZERO;
  logic [WEIGHT_W-1:0]  in_job_weight = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [JOBNUM_W-1:0]  out_job_number;
  logic [MIDX_W-1:0]    out_machine_index;
  logic [LOAD_W-1:0]    out_machine_load;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FACTOR_W-1:0]  cfg_wdata = '0;

  assignment_ledger ledger;
  bit               sender_idling = 1'b1;
  bit               receiver_idling = 1'b1;
  bit               hold_off_pending = 1'b0;
  int               hold_left = 0;
  int               cycle_count = 0;

  least_loaded_job_assigner #(
    .NUM_MACHINES(MACHINES)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_job_mode       (in_job_mode),
    .in_job_weight     (in_job_weight),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_job_number    (out_job_number),
    .out_machine_index (out_machine_index),
    .out_machine_load  (out_machine_load),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL least_loaded_job_assigner");
      $finish;
    end
  end

  // sample every transfer on the edge that completes it
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) ledger.write_register(cfg_index, cfg_wdata);
    if (rst_n && in_valid && !in_stall) ledger.predict_assignment(in_job_mode, in_job_weight);
    if (rst_n && out_valid && !out_stall)
      ledger.check_assignment(out_job_number, out_machine_index, out_machine_load);
  end

  // result side: random stalls, or one long hold-off on request
  always @(posedge clk) begin
    if (hold_off_pending) begin
      hold_off_pending = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_idling && ($urandom_range(99) < 33);
    end
  end

  task automatic send_job(input logic mode, input logic [WEIGHT_W-1:0] weight);
    while (sender_idling && ($urandom_range(99) < 33)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_job_mode <= mode;
    in_job_weight <= weight;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [FACTOR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // both factors, then a write to an unused index that must be dropped
  task automatic program_factors(input logic [FACTOR_W-1:0] zero_factor,
                                 input logic [FACTOR_W-1:0] one_factor);
    write_register(REG_FACTOR_MODE_ZERO, zero_factor);
    write_register(REG_FACTOR_MODE_ONE, one_factor);
    write_register(CFG_IDX_W'($urandom_range(REG_FACTOR_MODE_ONE + 1, 2 ** CFG_IDX_W - 1)),
                   FACTOR_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // step past the last accepting edge before looking at the queue
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending_assignments.size() != 0);
  endtask

  function automatic logic [FACTOR_W-1:0] pick_factor();
    case ($urandom_range(3))
      0: return '0;
      1: return FACTOR_MAX;
      default: return FACTOR_W'($urandom_range(2 ** FACTOR_W - 1));
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return WEIGHT_MAX;
      default: return WEIGHT_W'($urandom_range(2 ** WEIGHT_W - 1));
    endcase
  endfunction

  initial begin
    ledger = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset factors, all loads tied at zero
    send_job(MODE_ZERO, '0);
    send_job(MODE_ZERO, WEIGHT_MAX);
    send_job(MODE_ONE, WEIGHT_MAX);
    send_job(MODE_ONE, '0);
    send_job(MODE_ZERO, 8'h55);
    send_job(MODE_ONE, 8'hAA);
    finish_phase();

    program_factors(FACTOR_MAX, FACTOR_MAX);
    send_job(MODE_ZERO, WEIGHT_MAX);
    send_job(MODE_ONE, WEIGHT_MAX);
    send_job(MODE_ZERO, 8'h01);
    send_job(MODE_ONE, 8'h80);
    finish_phase();

    // zero factors: jobs are placed and counted but add nothing
    program_factors('0, '0);
    send_job(MODE_ZERO, WEIGHT_MAX);
    send_job(MODE_ONE, WEIGHT_MAX);
    send_job(MODE_ZERO, 8'h07);
    finish_phase();

    program_factors(FACTOR_W'(1), FACTOR_MAX);
    send_job(MODE_ZERO, WEIGHT_MAX);
    send_job(MODE_ONE, WEIGHT_MAX);
    send_job(MODE_ONE, '0);
    send_job(MODE_ZERO, 8'h5A);
    finish_phase();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      sender_idling = (phase != 2);
      receiver_idling = (phase != 2);
      case (phase)
        0: program_factors(FACTOR_MAX, FACTOR_W'(1));
        1: program_factors('0, FACTOR_MAX);
        default: program_factors(pick_factor(), pick_factor());
      endcase
      for (int n = 0; n < JOBS_PER_PHASE; n++) begin
        // long result hold-off while jobs keep coming
        if (phase == 3 && n == 20) hold_off_pending = 1'b1;
        send_job(1'($urandom_range(1)), pick_weight());
      end
      finish_phase();
    end

    // back-to-back heavy jobs
    sender_idling = 1'b0;
    receiver_idling = 1'b0;
    program_factors(FACTOR_MAX, FACTOR_MAX);
    for (int n = 0; n < BURST_JOBS; n++) begin
      send_job(1'($urandom_range(1)), WEIGHT_W'($urandom_range(192, 2 ** WEIGHT_W - 1)));
    end
    finish_phase();
    repeat (4 * MACHINES) @(posedge clk);

    if (ledger.mismatch_count == 0) begin
      $display("PASS least_loaded_job_assigner");
    end else begin
      $display("FAIL least_loaded_job_assigner");
    end
    $finish;
  end

endmodule
